// ===== rtl/dns_a_record_extractor_core_assert.svh =====
// Assertion macros used by the checker file of this block.
// Both forms sample on the rising clock and are disabled while reset is held.
`ifndef DNS_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH
`define DNS_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNSX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DNSX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dnsx_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsx_pkg
// Types and constants shared by the DNS A-record extractor modules.
// ----------------------------------------------------------------------------
package dnsx_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NO_A  = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // Fixed offsets and lengths within the packet.
  localparam logic [3:0] HDR_QD_HI   = 4'd4;
  localparam logic [3:0] HDR_QD_LO   = 4'd5;
  localparam logic [3:0] HDR_AN_HI   = 4'd6;
  localparam logic [3:0] HDR_AN_LO   = 4'd7;
  localparam logic [3:0] HDR_LAST    = 4'd11;
  localparam logic [3:0] QTAIL_LAST  = 4'd3;
  localparam logic [3:0] ATAIL_TY_HI = 4'd0;
  localparam logic [3:0] ATAIL_TY_LO = 4'd1;
  localparam logic [3:0] ATAIL_RD_HI = 4'd8;
  localparam logic [3:0] ATAIL_RD_LO = 4'd9;
  localparam logic [3:0] ADDR_LAST   = 4'd3;

  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] ADDR_LEN = 16'd4;

  // Default queue depths.
  localparam int IN_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF = 2;

  // One packet byte after classification.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ptr;
    logic       is_zero;
  } item_t;

  // One result.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ipv4_address;
  } result_t;

endpackage

// ===== rtl/dnsx_fifo.sv =====
// ----------------------------------------------------------------------------
// dnsx_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module dnsx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/dnsx_front.sv =====
// ----------------------------------------------------------------------------
// dnsx_front
// Accepts packet bytes, tags each one for the name parser and queues it.
// ----------------------------------------------------------------------------
module dnsx_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  output logic            in_full,
  input  logic            item_take,
  output dnsx_pkg::item_t item,
  output logic            item_valid
);

  import dnsx_pkg::*;

  item_t cls;
  logic  q_empty;

  // A label count with either top bit set starts a compression pointer.
  always_comb begin
    cls.data_byte = in_data_byte;
    cls.last_byte = in_last_byte;
    cls.is_ptr    = in_data_byte[7] | in_data_byte[6];
    cls.is_zero   = (in_data_byte == 8'h00);
  end

  dnsx_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata(cls),
    .full (in_full),
    .pop  (item_take),
    .rdata(item),
    .empty(q_empty)
  );

  assign item_valid = !q_empty;

endmodule

// ===== rtl/dnsx_parser.sv =====
// ----------------------------------------------------------------------------
// dnsx_parser
// Walks header, questions and answers one byte per cycle while the result
// queue has room, and produces the result of each packet.
// ----------------------------------------------------------------------------
module dnsx_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  dnsx_pkg::item_t   item,
  output logic              item_take,
  input  logic              res_full,
  output logic              res_push,
  output dnsx_pkg::result_t res
);

  import dnsx_pkg::*;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_QNAME  = 8'b0000_0010,
    PH_QTAIL  = 8'b0000_0100,
    PH_ANAME  = 8'b0000_1000,
    PH_ATAIL  = 8'b0001_0000,
    PH_RDATA  = 8'b0010_0000,
    PH_ADDR   = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] qd_r, qd_nxt;
  logic [15:0] an_r, an_nxt;
  logic [5:0]  lbl_r, lbl_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rdlen_r, rdlen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        sent_r, sent_nxt;

  logic        have;
  logic [1:0]  res_status;
  logic [31:0] res_addr;
  logic [15:0] an_dec;
  logic [15:0] rd_dec;
  logic        name_end;
  phase_t      tail_phase;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take && have;
  assign an_dec    = an_r - 16'd1;
  assign rd_dec    = rdlen_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    qd_nxt     = qd_r;
    an_nxt     = an_r;
    lbl_nxt    = lbl_r;
    rtype_nxt  = rtype_r;
    rdlen_nxt  = rdlen_r;
    acc_nxt    = acc_r;
    sent_nxt   = sent_r;
    have       = 1'b0;
    res_status = STATUS_FOUND;
    res_addr   = '0;
    name_end   = 1'b0;
    tail_phase = (phase_r == PH_QNAME) ? PH_QTAIL : PH_ATAIL;

    if (item_take) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == HDR_QD_HI) begin
            qd_nxt = {item.data_byte, 8'h00};
          end else if (pos_r == HDR_QD_LO) begin
            qd_nxt = qd_r | {8'h00, item.data_byte};
          end else if (pos_r == HDR_AN_HI) begin
            an_nxt = {item.data_byte, 8'h00};
          end else if (pos_r == HDR_AN_LO) begin
            an_nxt = an_r | {8'h00, item.data_byte};
          end
          if (pos_r == HDR_LAST) begin
            if (qd_r != 16'd0) begin
              phase_nxt = PH_QNAME;
              lbl_nxt   = '0;
              pos_nxt   = '0;
            end else if (an_r == 16'd0) begin
              have      = 1'b1;
              res_status = STATUS_NO_A;
              sent_nxt  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_ANAME;
              lbl_nxt   = '0;
              pos_nxt   = '0;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (lbl_r != 6'd0) begin
            lbl_nxt = lbl_r - 6'd1;
            // The second pointer byte closes the name.
            if (lbl_r == 6'd1 && pos_r == 4'd1) begin
              name_end = 1'b1;
            end
          end else if (item.is_ptr) begin
            lbl_nxt = 6'd1;
            pos_nxt = 4'd1;
          end else if (!item.is_zero) begin
            lbl_nxt = item.data_byte[5:0];
          end else begin
            name_end = 1'b1;
          end
          if (name_end) begin
            phase_nxt = tail_phase;
            pos_nxt   = '0;
          end
        end
        PH_QTAIL: begin
          if (pos_r == QTAIL_LAST) begin
            qd_nxt = qd_r - 16'd1;
            if (qd_r != 16'd1) begin
              phase_nxt = PH_QNAME;
              lbl_nxt   = '0;
              pos_nxt   = '0;
            end else if (an_r == 16'd0) begin
              have       = 1'b1;
              res_status = STATUS_NO_A;
              sent_nxt   = 1'b1;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_ANAME;
              lbl_nxt   = '0;
              pos_nxt   = '0;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_ATAIL: begin
          if (pos_r == ATAIL_TY_HI) begin
            rtype_nxt = {item.data_byte, 8'h00};
          end else if (pos_r == ATAIL_TY_LO) begin
            rtype_nxt = rtype_r | {8'h00, item.data_byte};
          end else if (pos_r == ATAIL_RD_HI) begin
            rdlen_nxt = {item.data_byte, 8'h00};
          end else if (pos_r == ATAIL_RD_LO) begin
            rdlen_nxt = rdlen_r | {8'h00, item.data_byte};
          end
          if (pos_r == ATAIL_RD_LO) begin
            pos_nxt = '0;
            if (rtype_r == TYPE_A && rdlen_nxt == ADDR_LEN) begin
              phase_nxt = PH_ADDR;
              acc_nxt   = '0;
            end else if (rdlen_nxt != 16'd0) begin
              phase_nxt = PH_RDATA;
            end else begin
              an_nxt = an_dec;
              if (an_dec == 16'd0) begin
                have       = 1'b1;
                res_status = STATUS_NO_A;
                sent_nxt   = 1'b1;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_ANAME;
                lbl_nxt   = '0;
              end
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_RDATA: begin
          rdlen_nxt = rd_dec;
          if (rd_dec == 16'd0) begin
            an_nxt = an_dec;
            if (an_dec == 16'd0) begin
              have       = 1'b1;
              res_status = STATUS_NO_A;
              sent_nxt   = 1'b1;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_ANAME;
              lbl_nxt   = '0;
              pos_nxt   = '0;
            end
          end
        end
        PH_ADDR: begin
          acc_nxt = {acc_r[23:0], item.data_byte};
          if (pos_r == ADDR_LAST) begin
            have       = 1'b1;
            res_status = STATUS_FOUND;
            res_addr   = acc_nxt;
            sent_nxt   = 1'b1;
            phase_nxt  = PH_DONE;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // The final byte reports truncation unless a result was already given,
      // and then returns the parser to its start state.
      if (item.last_byte) begin
        if (!have && !sent_r) begin
          have       = 1'b1;
          res_status = STATUS_TRUNC;
          res_addr   = '0;
        end
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        qd_nxt    = '0;
        an_nxt    = '0;
        lbl_nxt   = '0;
        rtype_nxt = '0;
        rdlen_nxt = '0;
        acc_nxt   = '0;
        sent_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    res.status       = res_status;
    res.ipv4_address = res_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      qd_r    <= '0;
      an_r    <= '0;
      lbl_r   <= '0;
      rtype_r <= '0;
      rdlen_r <= '0;
      acc_r   <= '0;
      sent_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      qd_r    <= qd_nxt;
      an_r    <= an_nxt;
      lbl_r   <= lbl_nxt;
      rtype_r <= rtype_nxt;
      rdlen_r <= rdlen_nxt;
      acc_r   <= acc_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

// ===== rtl/dns_a_record_extractor_core.sv =====
// Streaming DNS response reader that returns the first IPv4 address record.
// Input channel: one packet byte per transfer (in_data_byte) with in_last_byte
// marking the final byte; a transfer happens when in_push is high and in_full
// is low. Result channel: out_status and out_ipv4_address show the oldest
// result while out_empty is low; out_pop takes it.
// Each packet gives at most one result: address found, no A record among the
// answers, or truncation when the packet ends before a decision.
// Throughput is one byte per cycle while the result queue is not full.
// The byte that decides a result is registered in the input queue; the
// parser step that takes it pushes the result into the result queue, and
// out_empty goes low once the result is stored there.
// When the receiver stalls, results collect in the result queue; once it is
// full the parser holds and the input queue fills, raising in_full.
// A synchronous reset (rst_n low) empties both queues and returns the parser
// to the header of a new packet.
// ----------------------------------------------------------------------------
// dns_a_record_extractor_core
// Top level: classifying front queue, parser back end and result queue.
// ----------------------------------------------------------------------------
module dns_a_record_extractor_core #(
  parameter int IN_DEPTH  = dnsx_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = dnsx_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_status,
  output logic [31:0] out_ipv4_address
);

  import dnsx_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_full;
  logic    res_push;
  result_t res;
  result_t res_head;

  dnsx_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .in_full     (in_full),
    .item_take   (item_take),
    .item        (item),
    .item_valid  (item_valid)
  );

  dnsx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  dnsx_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_head),
    .empty(out_empty)
  );

  assign out_status       = res_head.status;
  assign out_ipv4_address = res_head.ipv4_address;

endmodule

// ===== rtl/dnsx_checker.sv =====
// ----------------------------------------------------------------------------
// dnsx_checker
// Port-level checks on the result channel of the A-record extractor.
// ----------------------------------------------------------------------------
`include "dns_a_record_extractor_core_assert.svh"

module dnsx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_pop,
  input logic        out_empty,
  input logic [1:0]  out_status,
  input logic [31:0] out_ipv4_address
);

  import dnsx_pkg::*;

  // Only the three defined status codes ever appear.
  `DNSX_ASSERT_SAME(a_status_legal, clk, rst_n, !out_empty, out_status == STATUS_FOUND || out_status == STATUS_NO_A || out_status == STATUS_TRUNC)

  // An address is reported only together with a found status.
  `DNSX_ASSERT_SAME(a_addr_zero, clk, rst_n, !out_empty && out_status != STATUS_FOUND, out_ipv4_address == 32'd0)

  // A waiting result is not withdrawn.
  `DNSX_ASSERT_NEXT(a_res_held, clk, rst_n, !out_empty && !out_pop, !out_empty)

  // A stalled result keeps its value.
  `DNSX_ASSERT_NEXT(a_res_stable, clk, rst_n, !out_empty && !out_pop, $stable(out_status) && $stable(out_ipv4_address))

endmodule

bind dns_a_record_extractor_core dnsx_checker u_dnsx_checker (.*);

// ===== sim/tb_dns_a_record_extractor_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_a_record_extractor_core
// Feeds DNS response packets byte by byte into the extractor and checks every
// result against a cycle-free parser written here. A short table of hand-built
// packets comes first, then random packets: mostly well-formed responses with
// random content, some cut short, some plain noise. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb_dns_a_record_extractor_core;
  import dnsx_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RAND_BYTES   = 1100;
  localparam int          MIN_RECORDS  = 40;
  localparam logic [7:0]  POINTER_MIN  = 8'd64;

  typedef enum logic [2:0] {
    P_HDR, P_QNAME, P_QFIX, P_ANAME, P_AFIX, P_SKIP, P_ADDR, P_DONE
  } phase_e;

  // How a table row gets its expected result.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;

  typedef struct {
    logic [7:0] b;
    logic       last;
    check_e     chk;
    result_t    rec;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        in_full;
  logic        out_pop;
  logic        out_empty;
  logic [1:0]  out_status;
  logic [31:0] out_ipv4_address;

  dns_a_record_extractor_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_status       (out_status),
    .out_ipv4_address (out_ipv4_address)
  );

  // Parser state of the predictor.
  phase_e      ph;
  logic [3:0]  pos;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [5:0]  lab_left;
  logic [15:0] rtype;
  logic [15:0] rd_left;
  logic [31:0] acc;
  logic        done;
  bit          got;
  result_t     got_rec;

  result_t     due_records[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  frame[$];
  int          mismatch_count;
  int          records_due;
  int          rand_bytes;
  int          cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_parser();
    ph       = P_HDR;
    pos      = '0;
    qd_left  = '0;
    an_left  = '0;
    lab_left = '0;
    rtype    = '0;
    rd_left  = '0;
    acc      = '0;
    done     = 1'b0;
  endfunction

  function automatic void post_result(logic [1:0] st, logic [31:0] a);
    got                  = 1'b1;
    got_rec.status       = st;
    got_rec.ipv4_address = a;
    done                 = 1'b1;
    ph                   = P_DONE;
  endfunction

  function automatic void open_name(phase_e p);
    ph       = p;
    lab_left = '0;
    pos      = '0;
  endfunction

  function automatic void open_answers();
    if (an_left == 16'd0) post_result(STATUS_NO_A, '0);
    else open_name(P_ANAME);
  endfunction

  function automatic void close_answer();
    an_left = an_left - 16'd1;
    open_answers();
  endfunction

  // A pending pointer byte is marked by pos == 1 while one byte remains.
  function automatic void name_step(logic [7:0] b, phase_e tail);
    if (lab_left != 6'd0) begin
      lab_left = lab_left - 6'd1;
      if (lab_left == 6'd0 && pos == 4'd1) begin
        ph  = tail;
        pos = '0;
      end
    end else if (b >= POINTER_MIN) begin
      lab_left = 6'd1;
      pos      = 4'd1;
    end else if (b != 8'd0) begin
      lab_left = b[5:0];
    end else begin
      ph  = tail;
      pos = '0;
    end
  endfunction

  function automatic void parse_step(logic [7:0] b, logic last);
    got     = 1'b0;
    got_rec = '0;
    case (ph)
      P_HDR: begin
        if (pos == HDR_QD_HI) qd_left = {b, 8'h00};
        else if (pos == HDR_QD_LO) qd_left = qd_left | {8'h00, b};
        else if (pos == HDR_AN_HI) an_left = {b, 8'h00};
        else if (pos == HDR_AN_LO) an_left = an_left | {8'h00, b};
        if (pos == HDR_LAST) begin
          if (qd_left != 16'd0) open_name(P_QNAME);
          else open_answers();
        end else begin
          pos = pos + 4'd1;
        end
      end
      P_QNAME: name_step(b, P_QFIX);
      P_QFIX: begin
        if (pos == QTAIL_LAST) begin
          qd_left = qd_left - 16'd1;
          if (qd_left != 16'd0) open_name(P_QNAME);
          else open_answers();
        end else begin
          pos = pos + 4'd1;
        end
      end
      P_ANAME: name_step(b, P_AFIX);
      P_AFIX: begin
        if (pos == ATAIL_TY_HI) rtype = {b, 8'h00};
        else if (pos == ATAIL_TY_LO) rtype = rtype | {8'h00, b};
        else if (pos == ATAIL_RD_HI) rd_left = {b, 8'h00};
        else if (pos == ATAIL_RD_LO) rd_left = rd_left | {8'h00, b};
        if (pos == ATAIL_RD_LO) begin
          pos = '0;
          if (rtype == TYPE_A && rd_left == ADDR_LEN) begin
            ph  = P_ADDR;
            acc = '0;
          end else if (rd_left != 16'd0) begin
            ph = P_SKIP;
          end else begin
            close_answer();
          end
        end else begin
          pos = pos + 4'd1;
        end
      end
      P_SKIP: begin
        rd_left = rd_left - 16'd1;
        if (rd_left == 16'd0) close_answer();
      end
      P_ADDR: begin
        acc = {acc[23:0], b};
        if (pos == ADDR_LAST) post_result(STATUS_FOUND, acc);
        else pos = pos + 4'd1;
      end
      default: ;
    endcase
    if (last && !got && !done) post_result(STATUS_TRUNC, '0);
    if (last) clear_parser();
  endfunction

  function automatic int draw_wait(bit on);
    return on ? int'($urandom_range(0, 4)) : 0;
  endfunction

  function automatic void add_row(logic [7:0] b, logic last, check_e chk,
                                  logic [1:0] st);
    stim_row_t r;
    r.b                = b;
    r.last             = last;
    r.chk              = chk;
    r.rec.status       = st;
    r.rec.ipv4_address = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void put_name();
    int n;
    int len;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 3);
      frame.push_back(8'(len));
      repeat (len) frame.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 1) begin
      frame.push_back(8'($urandom_range(64, 255)));
      frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      frame.push_back(8'd0);
    end
  endfunction

  function automatic void put_answer();
    logic [15:0] rt;
    logic [15:0] rl;
    case ($urandom_range(0, 3))
      0: begin
        rt = TYPE_A;
        rl = ADDR_LEN;
      end
      1: begin
        rt = TYPE_A;
        case ($urandom_range(0, 4))
          0: rl = 16'd0;
          1: rl = 16'd3;
          2: rl = 16'd5;
          3: rl = 16'd8;
          default: rl = ($urandom_range(0, 7) == 0) ? 16'h0104 : 16'd2;
        endcase
      end
      2: begin
        rt = 16'($urandom_range(0, 65535));
        rl = 16'($urandom_range(0, 6));
      end
      default: begin
        // Low byte says A but the high byte usually does not.
        rt = {8'($urandom_range(0, 255)), 8'h01};
        rl = ADDR_LEN;
      end
    endcase
    put_name();
    frame.push_back(rt[15:8]);
    frame.push_back(rt[7:0]);
    repeat (6) frame.push_back(8'($urandom_range(0, 255)));
    frame.push_back(rl[15:8]);
    frame.push_back(rl[7:0]);
    repeat (rl) frame.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed responses; some are cut short, some are noise.
  function automatic void build_frame();
    int mode;
    int qd;
    int an;
    frame.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 3);
      repeat (12) frame.push_back(8'($urandom_range(0, 255)));
      frame[HDR_QD_HI] = 8'd0;
      frame[HDR_QD_LO] = 8'(qd);
      frame[HDR_AN_HI] = 8'd0;
      frame[HDR_AN_LO] = 8'(an);
      repeat (qd) begin
        put_name();
        repeat (4) frame.push_back(8'($urandom_range(0, 255)));
      end
      repeat (an) put_answer();
      if (mode == 1) frame = frame[0:$urandom_range(0, frame.size() - 1)];
      else repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last, input check_e chk,
                           input result_t rec);
    int gap;
    gap = draw_wait(tx_idle_on);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_step(b, last);
    if (chk == CHK_ONE) begin
      due_records.push_back(rec);
      records_due++;
    end else if (chk == CHK_MODEL && got) begin
      due_records.push_back(got_rec);
      records_due++;
    end
    @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    out_pop        = 1'b0;
    mismatch_count = 0;
    records_due    = 0;
    rand_bytes     = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    clear_parser();

    // A lone final byte is a truncated packet.
    add_row(8'hFF, 1'b1, CHK_ONE, STATUS_TRUNC);
    // All-zero header: no questions and no answers, decided on the last
    // header byte; the bytes after the result give nothing.
    for (int i = 0; i < 11; i++) add_row(8'h00, 1'b0, CHK_MODEL, STATUS_FOUND);
    add_row(8'h00, 1'b0, CHK_ONE, STATUS_NO_A);
    add_row(8'h5A, 1'b0, CHK_NONE, STATUS_FOUND);
    add_row(8'hFF, 1'b1, CHK_NONE, STATUS_FOUND);
    // All-ones header with zero counts, ending on the deciding byte.
    for (int i = 0; i < 11; i++) begin
      add_row((i >= HDR_QD_HI && i <= HDR_AN_LO) ? 8'h00 : 8'hFF, 1'b0, CHK_MODEL,
              STATUS_FOUND);
    end
    add_row(8'hFF, 1'b1, CHK_ONE, STATUS_NO_A);
    add_row(8'h00, 1'b1, CHK_ONE, STATUS_TRUNC);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].chk,
                                    dir_rows[i].rec);

    while (rand_bytes < RAND_BYTES || records_due < MIN_RECORDS) begin
      build_frame();
      if ($urandom_range(0, 3) == 0) tx_idle_on = !tx_idle_on;
      foreach (frame[i]) begin
        send_byte(frame[i], i == frame.size() - 1, CHK_MODEL, '0);
        rand_bytes++;
      end
    end
    in_push <= 1'b0;

    while (due_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && due_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int      w;
    result_t want;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
      w = draw_wait(rx_idle_on);
      if (w > 0) begin
        out_pop <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (due_records.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d address %h",
                 $time, out_status, out_ipv4_address);
        mismatch_count++;
      end else begin
        want = due_records.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   want.status, out_status);
          mismatch_count++;
        end
        if (out_ipv4_address !== want.ipv4_address) begin
          $display("%0t: address mismatch, expected %h actual %h", $time,
                   want.ipv4_address, out_ipv4_address);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish, %0d results still expected", $time,
             due_records.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dnsx_pkg.sv
rtl/dnsx_fifo.sv
rtl/dnsx_front.sv
rtl/dnsx_parser.sv
rtl/dns_a_record_extractor_core.sv
rtl/dnsx_checker.sv
sim/tb_dns_a_record_extractor_core.sv
